### design/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and codes of the address resolution cache
// Command codes, result kinds, field widths and the cache entry layout.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int IP_W   = 32;
	localparam int MAC_W  = 48;
	localparam int PORT_W = 4;
	localparam int AGE_W  = 8;
	localparam int RET_W  = 3;
	localparam int RAGE_W = 2;

	typedef enum logic [1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_MISS   = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		K_HIT     = 3'd0,
		K_MISS    = 3'd1,
		K_SEND    = 3'd2,
		K_RELEASE = 3'd3,
		K_UNREACH = 3'd4,
		K_STORED  = 3'd5,
		K_QUEUED  = 3'd6,
		K_NONE    = 3'd7
	} kind_t;

	// One word of the cache memory.
	typedef struct packed {
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		logic [AGE_W-1:0] age;
	} entry_t;

	// Register addresses (byte address bits [3:2]).
	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_RETRIES = 2'd1;
	localparam logic [1:0] REG_WAIT    = 2'd2;

endpackage

### design/arp_cache_with_retry_top.sv
// ----------------------------------------------------------------------------
// arp_cache_with_retry_top: IPv4-to-MAC cache with pending request retry
// Requests enter on the s_ stream, results leave on the m_ stream, and three
// timing registers sit behind the APB port.
// ----------------------------------------------------------------------------
// Usage:
// A request carries a command (lookup, insert reply, register miss, tick)
// with an IP, a MAC and a port. Each request yields one or more results on
// the m_ stream; m_tlast marks the final result of a request.
// The mappings live in a synchronous memory of ENTRIES words that is scanned
// one word per cycle through a registered read port. An insert into a full
// table also reduces the victim modulo ENTRIES, one that releases a request
// also emits the release, and a tick ages the mappings and then walks the
// pending request table.
// One request is worked on at a time; s_tready is high only while the
// block is idle. The next request may be taken while the final result
// still sits in the output register.
// When m_tready is low, the result waits in the output register and the
// sequencer stalls on the next result.
// Reset clears the valid bits of both tables, loads the victim LFSR with one
// and sets the timing registers to 15, 5 and 1. No clearing pass is needed.
module arp_cache_with_retry_top #(
	parameter int ENTRIES = 32,
	parameter int PENDING = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// command[1:0], ip_addr[33:2], mac_addr[81:34], port[85:82], zero pad
	input  logic [87:0] s_tdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// kind[2:0], out_ip[34:3], out_mac[82:35], out_port[86:83], zero pad
	output logic [87:0] m_tdata,
	output logic        m_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int PW = (PENDING > 1) ? $clog2(PENDING) : 1;
	localparam logic [AW:0] ENT_N = (AW+1)'(ENTRIES);
	localparam logic [PW:0] PEND_N = (PW+1)'(PENDING);
	localparam logic [8:0] ENT9 = 9'(ENTRIES);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_VMOD, S_INSWR, S_REL, S_RMISS, S_RQ, S_EMIT
	} state_t;

	state_t state_q, ret_q;

	// Configuration registers.
	logic [arpc_pkg::AGE_W-1:0]  timeout_q;
	logic [arpc_pkg::RET_W-1:0]  retries_q;
	logic [arpc_pkg::RAGE_W-1:0] wait_q;
	logic                        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 8'd15;
			retries_q <= 3'd5;
			wait_q    <= 2'd1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				arpc_pkg::REG_TIMEOUT: timeout_q <= pwdata[7:0];
				arpc_pkg::REG_RETRIES: retries_q <= pwdata[2:0];
				arpc_pkg::REG_WAIT:    wait_q    <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[3:2])
			arpc_pkg::REG_TIMEOUT: prdata = {24'd0, timeout_q};
			arpc_pkg::REG_RETRIES: prdata = {29'd0, retries_q};
			arpc_pkg::REG_WAIT:    prdata = {30'd0, wait_q};
			default:               prdata = 32'd0;
		endcase
	end

	// Latched request.
	arpc_pkg::cmd_t                cmd_q;
	logic [arpc_pkg::IP_W-1:0]   ip_q;
	logic [arpc_pkg::MAC_W-1:0]  mac_q;
	logic [arpc_pkg::PORT_W-1:0] port_q;

	// Entry memory and its registered read port.
	arpc_pkg::entry_t mem [ENTRIES];
	arpc_pkg::entry_t rd_s1;
	logic [AW-1:0]    rd_addr;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	arpc_pkg::entry_t mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_s1 <= mem[rd_addr];
	end

	// Scan control.
	logic [ENTRIES-1:0] ev_q;
	logic [AW:0]        idx_q;
	logic               p_vld_s1;
	logic [AW-1:0]      p_idx_s1;
	logic               free_found_q;
	logic [AW-1:0]      free_idx_q;
	logic [7:0]         lfsr_q;
	logic [7:0]         vic_q;

	// Pending request table.
	logic [PENDING-1:0]        rv_q;
	logic [arpc_pkg::IP_W-1:0]   rip_q    [PENDING];
	logic [arpc_pkg::PORT_W-1:0] rport_q  [PENDING];
	logic [arpc_pkg::RET_W-1:0]  rret_q   [PENDING];
	logic [arpc_pkg::RAGE_W-1:0] rage_q   [PENDING];
	logic [PW:0]                 r_q;
	logic                        any_q;
	logic [arpc_pkg::PORT_W-1:0] rel_port_q;

	// Result staging and output register.
	arpc_pkg::kind_t             res_kind_q;
	logic [arpc_pkg::IP_W-1:0]   res_ip_q;
	logic [arpc_pkg::MAC_W-1:0]  res_mac_q;
	logic [arpc_pkg::PORT_W-1:0] res_port_q;
	logic                        res_last_q;
	logic                        m_valid_q;
	logic [86:0]                 m_data_q;
	logic                        m_last_q;
	logic                        emit_ok;

	assign emit_ok  = !m_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_data_q};
	assign m_tlast  = m_last_q;

	// Compare stage of the entry scan.
	logic                       cur_valid, cur_match;
	logic [arpc_pkg::AGE_W-1:0] new_age;
	logic                       scan_done;

	always_comb begin
		cur_valid = p_vld_s1 && ev_q[p_idx_s1];
		cur_match = cur_valid && (rd_s1.ip == ip_q);
		new_age   = (rd_s1.age == 8'hFF) ? rd_s1.age : rd_s1.age + 8'd1;
		scan_done = !p_vld_s1 && (idx_q == ENT_N);
		rd_addr   = idx_q[AW-1:0];
	end

	// Insert slot and memory write selection.
	logic [AW-1:0] ins_slot;

	always_comb begin
		ins_slot = free_found_q ? free_idx_q : vic_q[AW-1:0];
		mem_we   = 1'b0;
		mem_wa   = p_idx_s1;
		mem_wd   = '{ip: rd_s1.ip, mac: rd_s1.mac, age: new_age};
		if (state_q == S_INSWR) begin
			mem_we = 1'b1;
			mem_wa = ins_slot;
			mem_wd = '{ip: ip_q, mac: mac_q, age: '0};
		end else if (state_q == S_SCAN && cmd_q == arpc_pkg::CMD_TICK && cur_valid) begin
			mem_we = 1'b1;
		end
	end

	// Request table searches: release match, queued match, free slot, tick firing.
	logic          rel_hit, q_hit, rfree_hit;
	logic [PW-1:0] rel_idx, rfree_idx;
	logic [PENDING-1:0] fire;
	logic [arpc_pkg::RAGE_W-1:0] rnew_age [PENDING];
	logic          later_fire;

	always_comb begin
		rel_hit   = 1'b0;
		q_hit     = 1'b0;
		rfree_hit = 1'b0;
		rel_idx   = '0;
		rfree_idx = '0;
		later_fire = 1'b0;
		for (int j = PENDING - 1; j >= 0; j--) begin
			if (rv_q[j] && rip_q[j] == ip_q) begin
				rel_hit = 1'b1;
				rel_idx = PW'(j);
			end
			if (rv_q[j] && rip_q[j] == ip_q && rport_q[j] == port_q)
				q_hit = 1'b1;
			if (!rv_q[j]) begin
				rfree_hit = 1'b1;
				rfree_idx = PW'(j);
			end
		end
		for (int j = 0; j < PENDING; j++) begin
			rnew_age[j] = (rage_q[j] == 2'd3) ? rage_q[j] : rage_q[j] + 2'd1;
			fire[j]     = rv_q[j] && (rnew_age[j] > wait_q);
			if (fire[j] && (PW+1)'(j) > r_q)
				later_fire = 1'b1;
		end
	end

	// Sequencer: holds state, tables' control and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			ret_q        <= S_IDLE;
			ev_q         <= '0;
			rv_q         <= '0;
			lfsr_q       <= 8'd1;
			idx_q        <= '0;
			p_vld_s1     <= 1'b0;
			free_found_q <= 1'b0;
			r_q          <= '0;
			any_q        <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;
			p_vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q        <= arpc_pkg::cmd_t'(s_tdata[1:0]);
						ip_q         <= s_tdata[33:2];
						mac_q        <= s_tdata[81:34];
						port_q       <= s_tdata[85:82];
						idx_q        <= '0;
						free_found_q <= 1'b0;
						state_q      <= (s_tdata[1:0] == arpc_pkg::CMD_MISS) ? S_RMISS : S_SCAN;
					end
				end
				S_SCAN: begin
					// Issue the next read.
					if (idx_q != ENT_N) begin
						p_vld_s1 <= 1'b1;
						p_idx_s1 <= idx_q[AW-1:0];
						idx_q    <= idx_q + 1'b1;
					end
					if (p_vld_s1 && !ev_q[p_idx_s1] && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= p_idx_s1;
					end
					// Aging of one word per cycle during a tick.
					if (cmd_q == arpc_pkg::CMD_TICK && cur_valid && new_age > timeout_q)
						ev_q[p_idx_s1] <= 1'b0;
					res_ip_q   <= ip_q;
					res_mac_q  <= '0;
					res_port_q <= '0;
					res_last_q <= 1'b1;
					ret_q      <= S_IDLE;
					if (cmd_q != arpc_pkg::CMD_TICK && cur_match) begin
						p_vld_s1 <= 1'b0;
						state_q  <= S_EMIT;
						if (cmd_q == arpc_pkg::CMD_LOOKUP) begin
							res_kind_q <= arpc_pkg::K_HIT;
							res_mac_q  <= rd_s1.mac;
						end else begin
							res_kind_q <= arpc_pkg::K_NONE;
						end
					end else if (scan_done) begin
						case (cmd_q)
							arpc_pkg::CMD_LOOKUP: begin
								res_kind_q <= arpc_pkg::K_MISS;
								state_q    <= S_EMIT;
							end
							arpc_pkg::CMD_INSERT: begin
								vic_q   <= lfsr_q;
								state_q <= free_found_q ? S_INSWR : S_VMOD;
							end
							default: begin
								r_q     <= '0;
								any_q   <= 1'b0;
								state_q <= S_RQ;
							end
						endcase
					end
				end
				S_VMOD: begin
					// Reduce the victim modulo the table size.
					if ({1'b0, vic_q} >= ENT9)
						vic_q <= 8'({1'b0, vic_q} - ENT9);
					else
						state_q <= S_INSWR;
				end
				S_INSWR: begin
					ev_q[ins_slot] <= 1'b1;
					if (!free_found_q)
						lfsr_q <= lfsr_q[0] ? ((lfsr_q >> 1) ^ 8'hB8) : (lfsr_q >> 1);
					res_kind_q <= arpc_pkg::K_STORED;
					res_ip_q   <= ip_q;
					res_mac_q  <= mac_q;
					res_port_q <= '0;
					res_last_q <= !rel_hit;
					ret_q      <= rel_hit ? S_REL : S_IDLE;
					if (rel_hit) begin
						rv_q[rel_idx] <= 1'b0;
						rel_port_q    <= rport_q[rel_idx];
					end
					state_q <= S_EMIT;
				end
				S_REL: begin
					res_kind_q <= arpc_pkg::K_RELEASE;
					res_port_q <= rel_port_q;
					res_last_q <= 1'b1;
					ret_q      <= S_IDLE;
					state_q    <= S_EMIT;
				end
				S_RMISS: begin
					res_ip_q   <= ip_q;
					res_mac_q  <= '0;
					res_port_q <= port_q;
					res_last_q <= 1'b1;
					ret_q      <= S_IDLE;
					state_q    <= S_EMIT;
					if (q_hit) begin
						res_kind_q <= arpc_pkg::K_QUEUED;
					end else if (rfree_hit) begin
						rv_q[rfree_idx]    <= 1'b1;
						rip_q[rfree_idx]   <= ip_q;
						rport_q[rfree_idx] <= port_q;
						rret_q[rfree_idx]  <= '0;
						rage_q[rfree_idx]  <= '0;
						res_kind_q         <= arpc_pkg::K_SEND;
					end else begin
						res_kind_q <= arpc_pkg::K_NONE;
					end
				end
				S_RQ: begin
					// One pending request per cycle, but each firing one waits in S_EMIT until its result is taken.
					if (r_q == PEND_N) begin
						if (!any_q) begin
							res_kind_q <= arpc_pkg::K_NONE;
							res_ip_q   <= '0;
							res_mac_q  <= '0;
							res_port_q <= '0;
							res_last_q <= 1'b1;
							ret_q      <= S_IDLE;
							state_q    <= S_EMIT;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						r_q <= r_q + 1'b1;
						if (fire[r_q[PW-1:0]]) begin
							any_q      <= 1'b1;
							res_ip_q   <= rip_q[r_q[PW-1:0]];
							res_mac_q  <= '0;
							res_port_q <= rport_q[r_q[PW-1:0]];
							res_last_q <= !later_fire;
							ret_q      <= S_RQ;
							state_q    <= S_EMIT;
							if (rret_q[r_q[PW-1:0]] >= retries_q) begin
								rv_q[r_q[PW-1:0]] <= 1'b0;
								res_kind_q        <= arpc_pkg::K_UNREACH;
							end else begin
								rret_q[r_q[PW-1:0]] <= rret_q[r_q[PW-1:0]] + 3'd1;
								rage_q[r_q[PW-1:0]] <= '0;
								res_kind_q          <= arpc_pkg::K_SEND;
							end
						end else if (rv_q[r_q[PW-1:0]]) begin
							rage_q[r_q[PW-1:0]] <= rnew_age[r_q[PW-1:0]];
						end
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {res_port_q, res_mac_q, res_ip_q, res_kind_q};
						m_last_q  <= res_last_q;
						state_q   <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### design/arpc_checker.sv
// ----------------------------------------------------------------------------
// arpc_checker: port-level checks of the address resolution cache
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module arpc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [87:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tvalid,
	input logic        m_tready
);

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its contents.
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// Requests are worked one at a time.
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

	// Only stored, send and unreachable results can be followed by more.
	a_more: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |->
		m_tdata[2:0] == arpc_pkg::K_STORED || m_tdata[2:0] == arpc_pkg::K_SEND ||
		m_tdata[2:0] == arpc_pkg::K_UNREACH)
		else $error("non-final result of a kind that ends a request");

endmodule

bind arp_cache_with_retry_top arpc_checker u_arpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

### verif/arp_cache_with_retry_top_test.sv
// ----------------------------------------------------------------------------
// arp_cache_with_retry_top_test: self-checking bench of the ARP cache
// A short directed table, then random lookups, inserts, misses and ticks.
// Every result is checked against a cycle-free model of the cache and its
// pending request table under several timing register settings, with
// random gaps on the request stream and random stalls on the result stream.
// ----------------------------------------------------------------------------
module arp_cache_with_retry_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_ENT = 32;
	localparam int N_REQ = 8;
	localparam int IDLE_LIMIT = 5000;

	typedef struct {
		arpc_pkg::kind_t kind;
		logic [31:0]     ip;
		logic [47:0]     mac;
		logic [3:0]      port;
		logic            last;
	} arp_result_t;

	typedef struct {
		arpc_pkg::cmd_t  cmd;
		logic [31:0]     ip;
		logic [47:0]     mac;
		logic [3:0]      port;
		bit              typed;
		arpc_pkg::kind_t tkind;
	} arp_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [87:0] s_tdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] m_tdata;
	logic        m_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	arp_cache_with_retry_top #(.ENTRIES(N_ENT), .PENDING(N_REQ)) u_top (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Model of the cache state and timing registers.
	logic [7:0]  cfg_timeout = 8'd15;
	logic [2:0]  cfg_retries = 3'd5;
	logic [1:0]  cfg_wait = 2'd1;
	bit          map_valid [N_ENT];
	logic [31:0] map_ip [N_ENT];
	logic [47:0] map_mac [N_ENT];
	logic [7:0]  map_age [N_ENT];
	bit          pend_valid [N_REQ];
	logic [31:0] pend_ip [N_REQ];
	logic [3:0]  pend_port [N_REQ];
	logic [2:0]  pend_retries [N_REQ];
	logic [1:0]  pend_age [N_REQ];
	logic [7:0]  victim = 8'd1;

	arp_result_t expected_q [$];
	arp_row_t    directed_q [$];
	int          errors = 0;
	int          kind_seen [8];
	int          n_requests = 0;
	int          snd_idle = 0;
	int          rcv_stall = 0;
	int          rcv_hold = 0;
	int          quiet_cycles = 0;

	// Works out the results of one request and updates the model state.
	task automatic predict(arpc_pkg::cmd_t c, logic [31:0] ip, logic [47:0] mac,
			logic [3:0] port);
		arp_result_t res [$];
		int          slot;
		slot = -1;
		case (c)
			arpc_pkg::CMD_LOOKUP: begin
				for (int i = 0; i < N_ENT; i++)
					if (slot < 0 && map_valid[i] && map_ip[i] == ip)
						slot = i;
				if (slot >= 0)
					res.push_back('{arpc_pkg::K_HIT, ip, map_mac[slot], 4'd0, 1'b0});
				else
					res.push_back('{arpc_pkg::K_MISS, ip, 48'd0, 4'd0, 1'b0});
			end
			arpc_pkg::CMD_INSERT: begin
				for (int i = 0; i < N_ENT; i++)
					if (slot < 0 && map_valid[i] && map_ip[i] == ip)
						slot = i;
				if (slot >= 0) begin
					res.push_back('{arpc_pkg::K_NONE, ip, 48'd0, 4'd0, 1'b0});
				end else begin
					for (int i = 0; i < N_ENT; i++)
						if (slot < 0 && !map_valid[i])
							slot = i;
					if (slot < 0) begin
						slot = victim % N_ENT;
						victim = victim[0] ? ((victim >> 1) ^ 8'hB8) : (victim >> 1);
					end
					map_valid[slot] = 1'b1;
					map_ip[slot] = ip;
					map_mac[slot] = mac;
					map_age[slot] = 8'd0;
					res.push_back('{arpc_pkg::K_STORED, ip, mac, 4'd0, 1'b0});
					slot = -1;
					for (int i = 0; i < N_REQ; i++)
						if (slot < 0 && pend_valid[i] && pend_ip[i] == ip)
							slot = i;
					if (slot >= 0) begin
						pend_valid[slot] = 1'b0;
						res.push_back('{arpc_pkg::K_RELEASE, ip, mac, pend_port[slot], 1'b0});
					end
				end
			end
			arpc_pkg::CMD_MISS: begin
				for (int i = 0; i < N_REQ; i++)
					if (slot < 0 && pend_valid[i] && pend_ip[i] == ip && pend_port[i] == port)
						slot = i;
				if (slot >= 0) begin
					res.push_back('{arpc_pkg::K_QUEUED, ip, 48'd0, port, 1'b0});
				end else begin
					for (int i = 0; i < N_REQ; i++)
						if (slot < 0 && !pend_valid[i])
							slot = i;
					if (slot >= 0) begin
						pend_valid[slot] = 1'b1;
						pend_ip[slot] = ip;
						pend_port[slot] = port;
						pend_retries[slot] = 3'd0;
						pend_age[slot] = 2'd0;
						res.push_back('{arpc_pkg::K_SEND, ip, 48'd0, port, 1'b0});
					end else begin
						res.push_back('{arpc_pkg::K_NONE, ip, 48'd0, port, 1'b0});
					end
				end
			end
			default: begin
				// Age the mappings first, then walk the requests in slot order.
				for (int i = 0; i < N_ENT; i++) begin
					if (map_valid[i]) begin
						if (map_age[i] != 8'hFF)
							map_age[i]++;
						if (map_age[i] > cfg_timeout)
							map_valid[i] = 1'b0;
					end
				end
				for (int i = 0; i < N_REQ; i++) begin
					if (pend_valid[i]) begin
						if (pend_age[i] != 2'd3)
							pend_age[i]++;
						if (pend_age[i] > cfg_wait) begin
							if (pend_retries[i] >= cfg_retries) begin
								pend_valid[i] = 1'b0;
								res.push_back('{arpc_pkg::K_UNREACH, pend_ip[i], 48'd0,
									pend_port[i], 1'b0});
							end else begin
								pend_retries[i]++;
								pend_age[i] = 2'd0;
								res.push_back('{arpc_pkg::K_SEND, pend_ip[i], 48'd0,
									pend_port[i], 1'b0});
							end
						end
					end
				end
				if (res.size() == 0)
					res.push_back('{arpc_pkg::K_NONE, 32'd0, 48'd0, 4'd0, 1'b0});
			end
		endcase
		res[res.size()-1].last = 1'b1;
		foreach (res[i])
			expected_q.push_back(res[i]);
	endtask

	// Offers one request and waits until the cache takes it.
	task automatic send_request(arp_row_t r);
		arp_result_t typed_res;
		s_tdata <= {2'b0, r.port, r.mac, r.ip, r.cmd};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict(r.cmd, r.ip, r.mac, r.port);
		n_requests++;
		if (r.typed) begin
			// Single-result rows whose outcome is plain from the request itself.
			void'(expected_q.pop_back());
			typed_res.kind = r.tkind;
			typed_res.ip = (r.cmd == arpc_pkg::CMD_TICK) ? 32'd0 : r.ip;
			typed_res.mac = (r.tkind == arpc_pkg::K_STORED) ? r.mac : 48'd0;
			typed_res.port = 4'd0;
			typed_res.last = 1'b1;
			expected_q.push_back(typed_res);
		end
		if ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	function automatic arp_row_t mk(arpc_pkg::cmd_t c, logic [31:0] ip, logic [47:0] mac,
			logic [3:0] port, bit typed = 1'b0, arpc_pkg::kind_t k = arpc_pkg::K_HIT);
		arp_row_t r;
		r = '{c, ip, mac, port, typed, k};
		return r;
	endfunction

	// Mostly addresses from a small pool, so that requests meet earlier ones.
	function automatic arp_row_t rand_row();
		arp_row_t    r;
		int          pick;
		pick = $urandom_range(99);
		r.cmd = pick < 30 ? arpc_pkg::CMD_LOOKUP : pick < 55 ? arpc_pkg::CMD_INSERT :
			pick < 80 ? arpc_pkg::CMD_MISS : arpc_pkg::CMD_TICK;
		r.ip = ($urandom_range(99) < 85) ? (32'h0A00_0000 | $urandom_range(0, 11)) : $urandom;
		r.mac = 48'({$urandom, $urandom});
		r.port = ($urandom_range(99) < 75) ? 4'($urandom_range(0, 3)) : 4'($urandom);
		r.typed = 1'b0;
		r.tkind = arpc_pkg::K_HIT;
		return r;
	endfunction

	// Stops offering requests and waits for every outstanding result.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			arpc_pkg::REG_TIMEOUT: cfg_timeout = val[7:0];
			arpc_pkg::REG_RETRIES: cfg_retries = val[2:0];
			arpc_pkg::REG_WAIT:    cfg_wait = val[1:0];
			default: ;
		endcase
	endtask

	task automatic set_timing(logic [7:0] tmo, logic [2:0] ret, logic [1:0] wt);
		drain();
		reg_write(arpc_pkg::REG_TIMEOUT, {24'd0, tmo});
		reg_write(arpc_pkg::REG_RETRIES, {29'd0, ret});
		reg_write(arpc_pkg::REG_WAIT, {30'd0, wt});
	endtask

	// Result checker and stall generator of the output stream.
	always @(posedge clk) begin
		arp_result_t want;
		if (m_tvalid && m_tready) begin
			kind_seen[m_tdata[2:0]]++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual kind %0d ip %h mac %h port %h last %b",
					$time, m_tdata[2:0], m_tdata[34:3], m_tdata[82:35], m_tdata[86:83], m_tlast);
			end else begin
				want = expected_q.pop_front();
				if (m_tdata[2:0] !== want.kind || m_tdata[34:3] !== want.ip ||
						m_tdata[82:35] !== want.mac || m_tdata[86:83] !== want.port ||
						m_tlast !== want.last) begin
					errors++;
					$display("%0t: mismatch, expected kind %0d ip %h mac %h port %h last %b",
						$time, want.kind, want.ip, want.mac, want.port, want.last);
					$display("%0t:           actual kind %0d ip %h mac %h port %h last %b",
						$time, m_tdata[2:0], m_tdata[34:3], m_tdata[82:35], m_tdata[86:83],
						m_tlast);
				end
			end
		end
		if (rcv_hold > 0) begin
			rcv_hold <= rcv_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_stall);
		end
	end

	// Watchdog on cycles in which no handshake of any kind happens.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_q.size());
			$display("arp_cache_with_retry_top_test NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		// Directed rows: reset state, field extremes, every command and every outcome but unreachable.
		directed_q.push_back(mk(arpc_pkg::CMD_LOOKUP, 32'd0, 48'd0, 4'd0, 1'b1,
			arpc_pkg::K_MISS));
		directed_q.push_back(mk(arpc_pkg::CMD_TICK, 32'd0, 48'd0, 4'd0, 1'b1,
			arpc_pkg::K_NONE));
		directed_q.push_back(mk(arpc_pkg::CMD_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF,
			1'b1, arpc_pkg::K_STORED));
		directed_q.push_back(mk(arpc_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 48'd0, 4'd0));
		directed_q.push_back(mk(arpc_pkg::CMD_INSERT, 32'hFFFF_FFFF, 48'h1234, 4'd0, 1'b1,
			arpc_pkg::K_NONE));
		directed_q.push_back(mk(arpc_pkg::CMD_INSERT, 32'd0, 48'd0, 4'd0, 1'b1,
			arpc_pkg::K_STORED));
		directed_q.push_back(mk(arpc_pkg::CMD_LOOKUP, 32'd0, 48'hFFFF_FFFF_FFFF, 4'hF));
		directed_q.push_back(mk(arpc_pkg::CMD_MISS, 32'h0A00_0001, 48'd0, 4'hF));
		directed_q.push_back(mk(arpc_pkg::CMD_MISS, 32'h0A00_0001, 48'd0, 4'hF));
		directed_q.push_back(mk(arpc_pkg::CMD_MISS, 32'h0A00_0001, 48'd0, 4'h0));
		directed_q.push_back(mk(arpc_pkg::CMD_INSERT, 32'h0A00_0001, 48'h1234_5678_9ABC, 4'd0));
		directed_q.push_back(mk(arpc_pkg::CMD_TICK, 32'd0, 48'd0, 4'd0));
		directed_q.push_back(mk(arpc_pkg::CMD_TICK, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 4'hF));
		for (int i = 0; i < 9; i++)
			directed_q.push_back(mk(arpc_pkg::CMD_MISS, 32'hC0A8_0100 + i, 48'd0, 4'(i)));
		directed_q.push_back(mk(arpc_pkg::CMD_TICK, 32'd0, 48'd0, 4'd0));
		directed_q.push_back(mk(arpc_pkg::CMD_TICK, 32'd0, 48'd0, 4'd0));

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_q[i])
			send_request(directed_q[i]);

		// Phase one: no idling, long-lived mappings, table filled past its size.
		set_timing(8'd255, 3'd7, 2'd0);
		for (int i = 0; i < 35; i++)
			send_request(mk(arpc_pkg::CMD_INSERT, 32'h0B00_0000 + i,
				48'({$urandom, $urandom}), 4'd0));
		for (int i = 0; i < 15; i++)
			send_request(rand_row());

		// Phase two: gaps on the request side, mappings expire on the next tick.
		set_timing(8'd0, 3'd0, 2'd3);
		snd_idle = 61;
		for (int i = 0; i < 15; i++)
			send_request(rand_row());

		// Phase three: stalls on the result side and a long hold-off that backs
		// the cache up while requests keep coming.
		set_timing(8'd3, 3'd0, 2'd0);
		snd_idle = 0;
		rcv_stall = 61;
		rcv_hold = 250;
		for (int i = 0; i < 15; i++)
			send_request(rand_row());

		// Phase four: both sides idle now and then.
		set_timing(8'd15, 3'd2, 2'd1);
		snd_idle = 34;
		rcv_stall = 34;
		for (int i = 0; i < 15; i++)
			send_request(rand_row());

		drain();
		$display("%0d requests under four register settings; results by kind:", n_requests);
		$display("  hit %0d miss %0d send %0d release %0d unreach %0d stored %0d queued %0d none %0d",
			kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
			kind_seen[5], kind_seen[6], kind_seen[7]);
		if (errors == 0) begin
			$display("arp_cache_with_retry_top_test OK");
		end else begin
			$display("arp_cache_with_retry_top_test NOT OK");
		end
		$finish;
	end

endmodule
